/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AMOF_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AMOF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/amof_pkg.sv */
// Shared widths, defaults and payload types of the orientation frame unit.
`timescale 1ns / 1ps

package amof_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int SUM_W             = 32;
    localparam int ROOT_W            = 31;
    localparam int FRACTION_BITS_DEF = 14;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] mag_x;
        logic signed [SAMPLE_W-1:0] mag_y;
        logic signed [SAMPLE_W-1:0] mag_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] east_x;
        logic signed [SAMPLE_W-1:0] east_y;
        logic signed [SAMPLE_W-1:0] east_z;
        logic signed [SAMPLE_W-1:0] north_x;
        logic signed [SAMPLE_W-1:0] north_y;
        logic signed [SAMPLE_W-1:0] north_z;
        logic signed [SAMPLE_W-1:0] down_x;
        logic signed [SAMPLE_W-1:0] down_y;
        logic signed [SAMPLE_W-1:0] down_z;
        logic                       zero_vector;
    } frame_t;

endpackage

/* hw/rtl/amof_if.sv */
// Valid/ready channel interfaces for sensor sample requests and frame results.
`timescale 1ns / 1ps

interface amof_sample_if;
    logic              valid;
    logic              ready;
    amof_pkg::sample_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface amof_frame_if;
    logic             valid;
    logic             ready;
    amof_pkg::frame_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/amof_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
`timescale 1ns / 1ps

module amof_sqrt #(
    parameter int RW = amof_pkg::ROOT_W,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] radicand,
    input  logic [SW-1:0]   sb_in,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   sb_out
);

    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] x_reg    [RW];
    logic [SW-1:0]   sb_reg   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW:0]     rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] x_in;
        logic [SW-1:0]   sbk_in;
        logic [RW+2:0]   cur;
        logic [RW+2:0]   trial;
        logic [RW+2:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = radicand;
            assign sbk_in  = sb_in;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign sbk_in  = sb_reg[k-1];
        end

        // bring down the next bit pair and try root*4+1
        assign cur   = {rem_in, x_in[2*RW-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign diff  = cur - trial;
        assign ge    = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[RW:0] : cur[RW:0];
                root_reg[k] <= {root_in[RW-2:0], ge};
                x_reg[k]    <= {x_in[2*RW-3:0], 2'b00};
                sb_reg[k]   <= sbk_in;
            end
        end
    end

    assign root   = root_reg[RW-1];
    assign sb_out = sb_reg[RW-1];

endmodule

/* hw/rtl/amof_div.sv */
// Pipelined restoring divider, several lanes, one quotient bit per stage.
`timescale 1ns / 1ps

module amof_div #(
    parameter int NL = 6,
    parameter int NW = 46,
    parameter int DW = amof_pkg::ROOT_W,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num [NL],
    input  logic [DW-1:0] den [NL],
    input  logic [SW-1:0] sb_in,
    output logic [QW-1:0] quot [NL],
    output logic [SW-1:0] sb_out
);

    logic [DW-1:0] rem_reg  [QW][NL];
    logic [QW-1:0] lo_reg   [QW][NL];
    logic [QW-1:0] quot_reg [QW][NL];
    logic [DW-1:0] den_reg  [QW][NL];
    logic [SW-1:0] sb_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in  [NL];
        logic [QW-1:0] lo_in   [NL];
        logic [QW-1:0] quot_in [NL];
        logic [DW-1:0] den_in  [NL];
        logic [SW-1:0] sbk_in;
        logic [DW:0]   cur     [NL];
        logic [DW:0]   diff    [NL];
        logic          ge      [NL];

        for (genvar l = 0; l < NL; l++) begin : g_lane
            if (k == 0) begin : g_first
                // the quotient fits QW bits, so the top of the numerator is below den
                assign rem_in[l]  = DW'(num[l][NW-1:QW]);
                assign lo_in[l]   = num[l][QW-1:0];
                assign quot_in[l] = '0;
                assign den_in[l]  = den[l];
            end
            else begin : g_rest
                assign rem_in[l]  = rem_reg[k-1][l];
                assign lo_in[l]   = lo_reg[k-1][l];
                assign quot_in[l] = quot_reg[k-1][l];
                assign den_in[l]  = den_reg[k-1][l];
            end

            assign cur[l]  = {rem_in[l], lo_in[l][QW-1-k]};
            assign diff[l] = cur[l] - {1'b0, den_in[l]};
            assign ge[l]   = (cur[l] >= {1'b0, den_in[l]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][l]  <= ge[l] ? diff[l][DW-1:0] : cur[l][DW-1:0];
                    lo_reg[k][l]   <= lo_in[l];
                    quot_reg[k][l] <= {quot_in[l][QW-2:0], ge[l]};
                    den_reg[k][l]  <= den_in[l];
                end
            end
        end

        if (k == 0) begin : g_sb_first
            assign sbk_in = sb_in;
        end
        else begin : g_sb_rest
            assign sbk_in = sb_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k] <= sbk_in;
            end
        end
    end

    assign quot   = quot_reg[QW-1];
    assign sb_out = sb_reg[QW-1];

endmodule

/* hw/rtl/amof_cross.sv */
// Two-stage fixed-point cross product: products, then difference with rounding.
`timescale 1ns / 1ps

module amof_cross #(
    parameter int PW = 16,
    parameter int QW = 16,
    parameter int F  = amof_pkg::FRACTION_BITS_DEF,
    parameter int OW = PW + QW + 2 - F,
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [PW-1:0] p [3],
    input  logic signed [QW-1:0] q [3],
    input  logic [SW-1:0]        sb_in,
    output logic signed [OW-1:0] r [3],
    output logic [SW-1:0]        sb_out
);

    localparam int PRW = PW + QW;
    localparam int DFW = PRW + 1;
    localparam logic [PRW+1:0] HALF = (PRW+2)'(1) << (F - 1);

    logic signed [PRW-1:0] pos_reg [3];
    logic signed [PRW-1:0] neg_reg [3];
    logic [SW-1:0]         sb0_reg;
    logic signed [OW-1:0]  r_reg   [3];
    logic [SW-1:0]         sb1_reg;

    logic signed [PRW-1:0] pos_next [3];
    logic signed [PRW-1:0] neg_next [3];
    logic signed [DFW-1:0] d        [3];
    logic [PRW+1:0]        t        [3];

    always_comb
    begin
        pos_next[0] = p[1] * q[2];
        neg_next[0] = p[2] * q[1];
        pos_next[1] = p[2] * q[0];
        neg_next[1] = p[0] * q[2];
        pos_next[2] = p[0] * q[1];
        neg_next[2] = p[1] * q[0];
    end

    // half away from zero: add half, less one when negative, then floor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d[i] = DFW'(pos_reg[i]) - DFW'(neg_reg[i]);
            t[i] = {d[i][DFW-1], d[i]} + HALF - {{(DFW){1'b0}}, d[i][DFW-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
            sb0_reg <= sb_in;
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= $signed(t[i][PRW+1:F]);
            end
            sb1_reg <= sb0_reg;
        end
    end

    assign r      = r_reg;
    assign sb_out = sb1_reg;

endmodule

/* hw/rtl/accel_mag_orientation_frame_unit.sv */
// Top level: orientation frame from one accelerometer and one magnetometer sample.
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+------------
//   sample   | in  | accel_x/y/z, mag_x/y/z          | valid/ready
//   frame    | out | east, north, down, zero_vector  | valid/ready
//
// One request per cycle while sample.ready is high; most of the latency comes from
// the 31-stage square root and the FRACTION_BITS+2-stage divider.
// Reset clears the stage valid bits and the output and skid valid flags only.
// A stalled frame is held in the output register; one more frame goes to the
// skid register, then the whole pipeline holds and sample.ready drops.
`timescale 1ns / 1ps

module accel_mag_orientation_frame_unit #(
    parameter int FRACTION_BITS = amof_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    amof_sample_if.sink   sample,
    amof_frame_if.source  frame
);

    localparam int SW_   = amof_pkg::SAMPLE_W;
    localparam int F     = FRACTION_BITS;
    localparam int RW    = amof_pkg::ROOT_W;
    localparam int QW    = F + 2;
    localparam int NW    = F + 32;
    localparam int AW    = F + 2;
    localparam int EW    = 2 * AW + 2 - F;
    localparam int NRW   = AW + EW + 2 - F;
    localparam int NV    = 3 + RW + 1 + QW + 1 + 4;
    localparam int SQ_SB = 3 * SW_ + 4;
    localparam int DV_SB = 7;
    localparam int C1_SB = 1 + 3 * AW;
    localparam int C2_SB = 1 + 3 * EW + 3 * AW;
    localparam logic [QW-1:0] UNIT_Q = QW'(1) << F;
    localparam logic signed [NRW-1:0] SAT_HI = NRW'(32767);
    localparam logic signed [NRW-1:0] SAT_LO = -NRW'(32768);

    function automatic logic signed [SW_-1:0] sat16(input logic signed [NRW-1:0] x);
        logic signed [SW_-1:0] res;
        if (x > SAT_HI)
            res = 16'sh7fff;
        else if (x < SAT_LO)
            res = 16'sh8000;
        else
            res = x[SW_-1:0];
        return res;
    endfunction

    logic pipe_en;
    logic [NV-1:0] v_reg;

    // stage 0: input register
    amof_pkg::sample_t smp_reg;
    logic signed [SW_-1:0] raw [6];

    // stage 1: squares, magnitudes, zero flags
    logic [31:0]     sq_reg  [6];
    logic [SW_-1:0]  mag_reg [6];
    logic [5:0]      neg_reg;
    logic            za_reg, zm_reg;
    logic signed [31:0] sq_next [6];

    // stage 2: sums of squares
    logic [amof_pkg::SUM_W-1:0] suma_reg, summ_reg;
    logic [SW_-1:0]  mag2_reg [6];
    logic [5:0]      neg2_reg;
    logic            za2_reg, zm2_reg;

    // square root lanes
    logic [RW-1:0]    root_a, root_m;
    logic [SQ_SB-1:0] sqa_sb, sqm_sb;

    // prepare stage
    logic [NW-1:0] num_reg [6];
    logic [RW-1:0] den_reg [6];
    logic [5:0]    neg3_reg;
    logic          z3_reg;

    logic [QW-1:0]    quot [6];
    logic [DV_SB-1:0] dv_sb;

    // finish stage
    logic signed [AW-1:0] a_reg [3];
    logic signed [AW-1:0] m_reg [3];
    logic                 z4_reg;

    logic signed [EW-1:0]  east [3];
    logic [C1_SB-1:0]      c1_sb;
    logic signed [AW-1:0]  a1 [3];
    logic signed [NRW-1:0] north [3];
    logic [C2_SB-1:0]      c2_sb;

    // output register and skid
    amof_pkg::frame_t result;
    amof_pkg::frame_t out_data_reg, skid_data_reg;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic load_out, load_skid, out_from_skid, fire;

    assign pipe_en      = !skid_valid_reg;
    assign sample.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (pipe_en)
        begin
            v_reg <= {v_reg[NV-2:0], sample.valid};
        end
    end

    assign raw[0] = smp_reg.accel_x;
    assign raw[1] = smp_reg.accel_y;
    assign raw[2] = smp_reg.accel_z;
    assign raw[3] = smp_reg.mag_x;
    assign raw[4] = smp_reg.mag_y;
    assign raw[5] = smp_reg.mag_z;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            sq_next[i] = raw[i] * raw[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            smp_reg <= sample.data;
            for (int i = 0; i < 6; i++)
            begin
                sq_reg[i]  <= $unsigned(sq_next[i]);
                mag_reg[i] <= raw[i][SW_-1] ? SW_'(-raw[i]) : raw[i];
                neg_reg[i] <= raw[i][SW_-1];
            end
            za_reg   <= (raw[0] == '0) && (raw[1] == '0) && (raw[2] == '0);
            zm_reg   <= (raw[3] == '0) && (raw[4] == '0) && (raw[5] == '0);
            suma_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            summ_reg <= sq_reg[3] + sq_reg[4] + sq_reg[5];
            mag2_reg <= mag_reg;
            neg2_reg <= neg_reg;
            za2_reg  <= za_reg;
            zm2_reg  <= zm_reg;
        end
    end

    amof_sqrt #(.RW(RW), .SW(SQ_SB)) u_sqrt_a (
        .clk      (clk),
        .en       (pipe_en),
        .radicand ({suma_reg, {(2*RW-amof_pkg::SUM_W){1'b0}}}),
        .sb_in    ({za2_reg, neg2_reg[2:0], mag2_reg[2], mag2_reg[1], mag2_reg[0]}),
        .root     (root_a),
        .sb_out   (sqa_sb)
    );

    amof_sqrt #(.RW(RW), .SW(SQ_SB)) u_sqrt_m (
        .clk      (clk),
        .en       (pipe_en),
        .radicand ({summ_reg, {(2*RW-amof_pkg::SUM_W){1'b0}}}),
        .sb_in    ({zm2_reg, neg2_reg[5:3], mag2_reg[5], mag2_reg[4], mag2_reg[3]}),
        .root     (root_m),
        .sb_out   (sqm_sb)
    );

    // numerator: magnitude scaled up, plus half the length for rounding
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i]   <= (NW'(sqa_sb[i*SW_ +: SW_]) << (F + 15))
                                + NW'(root_a[RW-1:1]);
                num_reg[i+3] <= (NW'(sqm_sb[i*SW_ +: SW_]) << (F + 15))
                                + NW'(root_m[RW-1:1]);
                den_reg[i]   <= root_a;
                den_reg[i+3] <= root_m;
            end
            neg3_reg <= {sqm_sb[3*SW_ +: 3], sqa_sb[3*SW_ +: 3]};
            z3_reg   <= sqa_sb[SQ_SB-1] | sqm_sb[SQ_SB-1];
        end
    end

    amof_div #(.NL(6), .NW(NW), .DW(RW), .QW(QW), .SW(DV_SB)) u_div (
        .clk    (clk),
        .en     (pipe_en),
        .num    (num_reg),
        .den    (den_reg),
        .sb_in  ({z3_reg, neg3_reg}),
        .quot   (quot),
        .sb_out (dv_sb)
    );

    // clamp to one, apply the sign; accel comes out negated
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= dv_sb[i]
                    ? $signed((quot[i] > UNIT_Q) ? UNIT_Q : quot[i])
                    : -$signed((quot[i] > UNIT_Q) ? UNIT_Q : quot[i]);
                m_reg[i] <= dv_sb[i+3]
                    ? -$signed((quot[i+3] > UNIT_Q) ? UNIT_Q : quot[i+3])
                    : $signed((quot[i+3] > UNIT_Q) ? UNIT_Q : quot[i+3]);
            end
            z4_reg <= dv_sb[DV_SB-1];
        end
    end

    amof_cross #(.PW(AW), .QW(AW), .F(F), .OW(EW), .SW(C1_SB)) u_cross_east (
        .clk    (clk),
        .en     (pipe_en),
        .p      (m_reg),
        .q      (a_reg),
        .sb_in  ({z4_reg, a_reg[2], a_reg[1], a_reg[0]}),
        .r      (east),
        .sb_out (c1_sb)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a1[i] = $signed(c1_sb[i*AW +: AW]);
        end
    end

    amof_cross #(.PW(AW), .QW(EW), .F(F), .OW(NRW), .SW(C2_SB)) u_cross_north (
        .clk    (clk),
        .en     (pipe_en),
        .p      (a1),
        .q      (east),
        .sb_in  ({c1_sb[C1_SB-1], east[2], east[1], east[0], a1[2], a1[1], a1[0]}),
        .r      (north),
        .sb_out (c2_sb)
    );

    always_comb
    begin
        result = '0;
        if (c2_sb[C2_SB-1])
        begin
            result.zero_vector = 1'b1;
        end
        else
        begin
            result.east_x  = sat16(NRW'($signed(c2_sb[3*AW +: EW])));
            result.east_y  = sat16(NRW'($signed(c2_sb[3*AW+EW +: EW])));
            result.east_z  = sat16(NRW'($signed(c2_sb[3*AW+2*EW +: EW])));
            result.north_x = sat16(north[0]);
            result.north_y = sat16(north[1]);
            result.north_z = sat16(north[2]);
            result.down_x  = sat16(NRW'($signed(c2_sb[0 +: AW])));
            result.down_y  = sat16(NRW'($signed(c2_sb[AW +: AW])));
            result.down_z  = sat16(NRW'($signed(c2_sb[2*AW +: AW])));
        end
    end

    assign fire = out_valid_reg & frame.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg & ~fire;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        priority if (skid_valid_reg && fire)
        begin
            out_from_skid   = 1'b1;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else if (pipe_en && v_reg[NV-1])
        begin
            if (!out_valid_reg || fire)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else
        begin
            // nothing arrives: hold the skid register
            skid_valid_next = skid_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
            out_data_reg <= skid_data_reg;
        else if (load_out)
            out_data_reg <= result;
        if (load_skid)
            skid_data_reg <= result;
    end

    assign frame.valid = out_valid_reg;
    assign frame.data  = out_data_reg;

endmodule

/* hw/rtl/amof_checker.sv */
// Port-level checker for the orientation frame unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amof_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input amof_pkg::frame_t out_data
);

    logic [7:0] cnt_reg, cnt_next;

    // requests accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg + 8'(in_valid & in_ready) - 8'(out_valid & out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    `AMOF_ASSERT(a_no_phantom, out_valid, cnt_reg != 8'd0, "frame with no request in flight")
    `AMOF_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled frame changed")
    `AMOF_ASSERT(a_zero_rows, out_valid && out_data.zero_vector, out_data.east_x == 0 && out_data.east_y == 0 && out_data.east_z == 0 && out_data.north_x == 0 && out_data.north_y == 0 && out_data.north_z == 0 && out_data.down_x == 0 && out_data.down_y == 0 && out_data.down_z == 0, "zero flag with non-zero rows")
    `AMOF_ASSERT(a_down_unit, out_valid && !out_data.zero_vector, out_data.down_x != 0 || out_data.down_y != 0 || out_data.down_z != 0, "down row empty for a non-zero sample")

endmodule

bind accel_mag_orientation_frame_unit amof_checker u_amof_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_data  (frame.data)
);

/* dv/accel_mag_orientation_frame_unit_tb.sv */
// Testbench of the orientation frame unit: directed table, random requests, frame prediction.
`timescale 1ns / 1ps

module accel_mag_orientation_frame_unit_tb;

    localparam int FRAC       = amof_pkg::FRACTION_BITS_DEF;
    localparam int LATENCY    = FRAC + 43;
    localparam int N_RANDOM   = 1100;
    localparam int QUIET_FROM = 900;

    typedef struct {
        amof_pkg::sample_t req;
        logic              typed;
        amof_pkg::frame_t  want;
    } row_t;

    logic clk;
    logic rst_n;

    amof_sample_if sample ();
    amof_frame_if  frame ();

    accel_mag_orientation_frame_unit #(.FRACTION_BITS(FRAC)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .frame  (frame.source)
    );

    amof_pkg::frame_t pending_frames[$];
    int     mismatches;
    int     frames_seen;
    int     zero_frames;
    int     requests_sent;
    bit     quiet;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned root_u64(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Scale to unit length in Q(FRAC); returns 0 on a zero-length vector.
    function automatic bit unit_q(input longint v[3], input longint sgn, output longint u[3]);
        longint unsigned s;
        longint unsigned len;
        longint unsigned mag;
        longint unsigned q;
        s = 0;
        for (int i = 0; i < 3; i++)
            s += longint'(v[i] * v[i]);
        if (s == 0)
            return 0;
        len = root_u64(s << 30);
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            q   = ((mag << (FRAC + 15)) + (len >> 1)) / len;
            if (q > (64'd1 << FRAC))
                q = 64'd1 << FRAC;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            u[i] = u[i] * sgn;
        end
        return 1;
    endfunction

    function automatic longint round_away(longint x);
        longint unsigned m;
        longint r;
        m = (x < 0) ? -x : x;
        r = longint'((m + (64'd1 << (FRAC - 1))) >> FRAC);
        return (x < 0) ? -r : r;
    endfunction

    function automatic logic signed [amof_pkg::SAMPLE_W-1:0] sat16(longint x);
        if (x > 32767)
            x = 32767;
        if (x < -32768)
            x = -32768;
        return x[amof_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic amof_pkg::frame_t predict_frame(amof_pkg::sample_t s);
        amof_pkg::frame_t f;
        longint acc[3];
        longint mg[3];
        longint a[3];
        longint m[3];
        longint e[3];
        longint n[3];
        f   = '0;
        acc = '{longint'(s.accel_x), longint'(s.accel_y), longint'(s.accel_z)};
        mg  = '{longint'(s.mag_x), longint'(s.mag_y), longint'(s.mag_z)};
        if (!unit_q(acc, -1, a) || !unit_q(mg, 1, m))
        begin
            f.zero_vector = 1'b1;
            return f;
        end
        e[0] = round_away(m[1] * a[2] - m[2] * a[1]);
        e[1] = round_away(m[2] * a[0] - m[0] * a[2]);
        e[2] = round_away(m[0] * a[1] - m[1] * a[0]);
        n[0] = round_away(a[1] * e[2] - a[2] * e[1]);
        n[1] = round_away(a[2] * e[0] - a[0] * e[2]);
        n[2] = round_away(a[0] * e[1] - a[1] * e[0]);
        f.east_x  = sat16(e[0]);
        f.east_y  = sat16(e[1]);
        f.east_z  = sat16(e[2]);
        f.north_x = sat16(n[0]);
        f.north_y = sat16(n[1]);
        f.north_z = sat16(n[2]);
        f.down_x  = sat16(a[0]);
        f.down_y  = sat16(a[1]);
        f.down_z  = sat16(a[2]);
        return f;
    endfunction

    function automatic amof_pkg::sample_t mk(int ax, int ay, int az, int mx, int my, int mz);
        amof_pkg::sample_t s;
        s.accel_x = ax[15:0];
        s.accel_y = ay[15:0];
        s.accel_z = az[15:0];
        s.mag_x   = mx[15:0];
        s.mag_y   = my[15:0];
        s.mag_z   = mz[15:0];
        return s;
    endfunction

    function automatic logic [15:0] rand_axis(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 15)) - 16'd8;
            1: return 16'($urandom_range(0, 4095)) - 16'd2048;
            2: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic amof_pkg::sample_t rand_sample();
        amof_pkg::sample_t s;
        int mode;
        mode      = $urandom_range(0, 9);
        mode      = (mode < 6) ? 3 : mode - 6;
        s.accel_x = rand_axis(mode);
        s.accel_y = rand_axis(mode);
        s.accel_z = rand_axis(mode);
        s.mag_x   = rand_axis(3);
        s.mag_y   = rand_axis(3);
        s.mag_z   = rand_axis(3);
        // occasional zero-length vector on either side
        case ($urandom_range(0, 29))
            0:
            begin
                s.accel_x = '0;
                s.accel_y = '0;
                s.accel_z = '0;
            end
            1:
            begin
                s.mag_x = '0;
                s.mag_y = '0;
                s.mag_z = '0;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("frame %0d %s: expected %0d, got %0d", frames_seen, name,
                         $signed(want), $signed(got));
        end
    endtask

    // Hold the request until the handshake completes, then queue its frame.
    task automatic send_request(amof_pkg::sample_t s, logic typed, amof_pkg::frame_t want);
        amof_pkg::frame_t p;
        sample.valid <= 1'b1;
        sample.data  <= s;
        do
            @(posedge clk);
        while (!sample.ready);
        p = predict_frame(s);
        if (typed && p !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row %0d: predictor disagrees with typed frame", requests_sent);
        end
        pending_frames.push_back(typed ? want : p);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && frame.valid && frame.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame at %0t", $realtime);
            end
            else
            begin
                amof_pkg::frame_t w;
                w = pending_frames.pop_front();
                check_field("east_x", w.east_x, frame.data.east_x);
                check_field("east_y", w.east_y, frame.data.east_y);
                check_field("east_z", w.east_z, frame.data.east_z);
                check_field("north_x", w.north_x, frame.data.north_x);
                check_field("north_y", w.north_y, frame.data.north_y);
                check_field("north_z", w.north_z, frame.data.north_z);
                check_field("down_x", w.down_x, frame.data.down_x);
                check_field("down_y", w.down_y, frame.data.down_y);
                check_field("down_z", w.down_z, frame.data.down_z);
                check_field("zero_vector", 16'(w.zero_vector), 16'(frame.data.zero_vector));
                if (w.zero_vector)
                    zero_frames++;
            end
            frames_seen++;
        end
    end

    // Stall the result side in bursts until the quiet stretch.
    initial
    begin
        frame.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                frame.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            frame.ready <= 1'b1;
            if (!quiet)
                repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    initial
    begin
        #5ms;
        $display("** accel_mag_orientation_frame_unit: FAILED **");
        $finish;
    end

    initial
    begin
        row_t   rows[$];
        row_t   r;
        amof_pkg::frame_t z;
        amof_pkg::frame_t ax;
        sample.valid = 1'b0;
        sample.data  = '0;
        rst_n        = 1'b0;
        mismatches   = 0;
        frames_seen  = 0;
        zero_frames  = 0;
        requests_sent = 0;
        quiet        = 0;
        z             = '0;
        z.zero_vector = 1'b1;
        ax         = '0;
        ax.east_z  = 16'sd16384;
        ax.north_y = 16'sd16384;
        ax.down_x  = -16'sd16384;

        rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1'b1, z});
        rows.push_back('{mk(0, 0, 0, 100, -5, 7), 1'b1, z});
        rows.push_back('{mk(-3, 9, 1, 0, 0, 0), 1'b1, z});
        rows.push_back('{mk(1000, 0, 0, 0, 1000, 0), 1'b1, ax});
        rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768), 1'b0, z});
        rows.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767), 1'b0, z});
        rows.push_back('{mk(-32768, 0, 0, 0, 0, 32767), 1'b0, z});
        rows.push_back('{mk(0, 32767, 0, -32768, 0, 0), 1'b0, z});
        rows.push_back('{mk(0, 0, -32768, 0, -32768, 0), 1'b0, z});
        rows.push_back('{mk(1, 0, 0, 0, 1, 0), 1'b0, z});
        rows.push_back('{mk(1, 1, 1, -1, -1, -1), 1'b0, z});
        rows.push_back('{mk(1, -1, 0, 1, 1, 0), 1'b0, z});
        rows.push_back('{mk(32767, -32768, 1, -1, 32767, -32768), 1'b0, z});
        rows.push_back('{mk(0, 0, 1, 0, 0, 1), 1'b0, z});
        rows.push_back('{mk(-1, 0, 0, 0, 0, 0), 1'b1, z});
        rows.push_back('{mk(300, -4000, 16000, 21000, 50, -9000), 1'b0, z});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            send_request(r.req, r.typed, r.want);
            sender_gap();
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                // drain the pipe before carrying on
                sample.valid <= 1'b0;
                while (pending_frames.size() != 0)
                    @(negedge clk);
            end
            if (i == QUIET_FROM)
                quiet = 1;
            send_request(rand_sample(), 1'b0, z);
            sender_gap();
        end
        sample.valid <= 1'b0;

        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);

        $display("%0d requests sent, %0d frames checked (%0d zero-length), %0d mismatches",
                 requests_sent, frames_seen, zero_frames, mismatches);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("** accel_mag_orientation_frame_unit: PASSED **");
        else
            $display("** accel_mag_orientation_frame_unit: FAILED **");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/amof_pkg.sv
hw/rtl/amof_if.sv
hw/rtl/amof_sqrt.sv
hw/rtl/amof_div.sv
hw/rtl/amof_cross.sv
hw/rtl/accel_mag_orientation_frame_unit.sv
hw/rtl/amof_checker.sv
dv/accel_mag_orientation_frame_unit_tb.sv
